// ===== rtl/sssc_pkg.sv =====
// Package for the scrolling seven-segment controller.
// Holds the buffer constants, the command codes, the payload structs and the font table.
// Depends on nothing.
package sssc_pkg;

	localparam int BUFFER_DEPTH = 50;
	localparam int MEM_AW = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = 6;
	localparam int PTR_W = 8;

	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [2:0] {
		FN_ADDR_WR = 3'd0,
		FN_DATA    = 3'd1,
		FN_ADDR_RD = 3'd2,
		FN_RD_NEXT = 3'd3,
		FN_SCROLL  = 3'd4,
		FN_MUX     = 3'd5
	} func_t;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic       is_read;
		logic [7:0] read_data;
		logic [1:0] digit_index;
		logic [6:0] segment_pattern;
	} res_t;

	// Buffer contents right after reset: the greeting, then zeros.
	function automatic logic [7:0] init_char(input logic [PTR_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			8'd0: c = 8'h68;
			8'd1: c = 8'h65;
			8'd2: c = 8'h6C;
			8'd3: c = 8'h6C;
			8'd4: c = 8'h6F;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] glyph(input logic [7:0] c);
		logic [6:0] g;
		case (c)
			"0", "O", "o": g = 7'h3F;
			"1", "I", "i": g = 7'h14;
			"2": g = 7'h6D;
			"3": g = 7'h5D;
			"4": g = 7'h56;
			"5", "S", "s": g = 7'h5B;
			"6": g = 7'h7B;
			"7": g = 7'h1C;
			"8": g = 7'h7F;
			"9": g = 7'h5E;
			"A", "a": g = 7'h7E;
			"B", "b": g = 7'h73;
			"C", "c": g = 7'h61;
			"D", "d": g = 7'h75;
			"E", "e": g = 7'h6B;
			"F", "f": g = 7'h6A;
			"G", "g": g = 7'h5F;
			"H", "h": g = 7'h76;
			"L", "l": g = 7'h23;
			"P", "p": g = 7'h6E;
			"R", "r": g = 7'h60;
			"T", "t": g = 7'h63;
			"U": g = 7'h37;
			"u": g = 7'h31;
			"Y", "y": g = 7'h57;
			"=": g = 7'h41;
			"_": g = 7'h01;
			default: g = 7'h00;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/scrolling_seven_segment_controller.sv =====
// Top level of the scrolling seven-segment controller.
// Holds the character buffer, the scroll and multiplex state and the result pipeline.
// Depends on sssc_pkg.
//
// Commands arrive on cmd/cmd_valid/cmd_ready, one transfer per command. Address
// write, data byte and scroll tick update internal state and produce no result.
// Address read, read next and multiplex tick each produce one result on
// res/res_valid/res_ready, in command order.
//
// A command can be taken in every cycle while the receiver does not stall. A
// result command reads the character buffer through its registered read port
// at its transfer edge; once the output register is free or being emptied, the
// byte or its font pattern is placed in the output register. State updates
// take effect at the transfer edge.
//
// When the receiver stalls, the output register holds its result and the read
// stage holds the next one; cmd_ready drops only once both are full. Commands
// without a result are still blocked in that case, so that order is kept.
//
// Reset restores the greeting string of length five, clears all counters and
// pointers and empties the pipeline. The buffer memory itself is not cleared:
// per-entry valid bits make unwritten entries read as their reset contents.
module scrolling_seven_segment_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  sssc_pkg::cmd_t  cmd,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	output sssc_pkg::res_t  res,
	output logic            res_valid,
	input  logic            res_ready
);

	logic [7:0] mem [sssc_pkg::BUFFER_DEPTH];

	logic [sssc_pkg::BUFFER_DEPTH-1:0] ent_valid_q;
	logic [3:0]                        pad_q;
	logic [sssc_pkg::CNT_W-1:0]        len_q;
	logic [sssc_pkg::CNT_W-1:0]        wc_q;
	logic [sssc_pkg::CNT_W-1:0]        win_q;
	logic [sssc_pkg::PTR_W-1:0]        rp_q;
	logic [1:0]                        phase_q;

	logic       valid_s1;
	logic       is_read_s1;
	logic [1:0] digit_s1;
	logic       in_range_s1;
	logic       pad_s1;
	logic       ent_valid_s1;
	logic [7:0] init_s1;
	logic [7:0] mem_s1;

	logic                 res_valid_q;
	sssc_pkg::res_t       res_q;

	logic                        accept;
	logic                        adv_s1;
	logic                        has_result;
	logic                        load_s1;
	logic                        is_printable;
	logic                        write_en;
	logic [sssc_pkg::PTR_W-1:0]  rd_addr;
	logic                        in_range;
	logic [sssc_pkg::MEM_AW-1:0] rd_idx;
	logic [sssc_pkg::CNT_W-1:0]  win_inc;
	logic [7:0]                  byte_s1;

	assign adv_s1 = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || adv_s1;
	assign accept = cmd_valid && cmd_ready;

	assign has_result = (cmd.func == sssc_pkg::FN_ADDR_RD) || (cmd.func == sssc_pkg::FN_RD_NEXT)
		|| (cmd.func == sssc_pkg::FN_MUX);
	assign load_s1 = accept && has_result;

	assign is_printable = cmd.data_byte >= sssc_pkg::CHAR_SPACE;
	assign write_en = accept && (cmd.func == sssc_pkg::FN_DATA) && is_printable
		&& (wc_q < sssc_pkg::CNT_W'(sssc_pkg::BUFFER_DEPTH));

	assign win_inc = win_q + sssc_pkg::CNT_W'(1);

	always_comb begin
		case (cmd.func)
			sssc_pkg::FN_ADDR_RD: rd_addr = rp_q;
			sssc_pkg::FN_RD_NEXT: rd_addr = rp_q + sssc_pkg::PTR_W'(1);
			default: rd_addr = sssc_pkg::PTR_W'({1'b0, win_q} + {5'd0, phase_q});
		endcase
	end

	assign in_range = rd_addr < sssc_pkg::PTR_W'(sssc_pkg::BUFFER_DEPTH);
	assign rd_idx = rd_addr[sssc_pkg::MEM_AW-1:0];

	always_ff @(posedge clk) begin
		if (write_en) begin
			mem[wc_q[sssc_pkg::MEM_AW-1:0]] <= cmd.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			is_read_s1 <= (cmd.func != sssc_pkg::FN_MUX);
			digit_s1 <= phase_q;
			in_range_s1 <= in_range;
			pad_s1 <= (rd_addr < sssc_pkg::PTR_W'(4)) ? pad_q[rd_addr[1:0]] : 1'b0;
			ent_valid_s1 <= in_range ? ent_valid_q[rd_idx] : 1'b0;
			init_s1 <= sssc_pkg::init_char(rd_addr);
			if (in_range) begin
				mem_s1 <= mem[rd_idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			pad_q <= '0;
			len_q <= sssc_pkg::CNT_W'(5);
			wc_q <= '0;
			win_q <= '0;
			rp_q <= '0;
			phase_q <= '0;
		end else if (accept) begin
			case (cmd.func)
				sssc_pkg::FN_ADDR_WR: begin
					wc_q <= '0;
					win_q <= '0;
				end
				sssc_pkg::FN_DATA: begin
					rp_q <= cmd.data_byte;
					if (!is_printable) begin
						len_q <= wc_q;
						wc_q <= '0;
					end else if (write_en) begin
						ent_valid_q[wc_q[sssc_pkg::MEM_AW-1:0]] <= 1'b1;
						if (wc_q < sssc_pkg::CNT_W'(4)) begin
							pad_q[wc_q[1:0]] <= 1'b0;
						end
						wc_q <= wc_q + sssc_pkg::CNT_W'(1);
					end
				end
				sssc_pkg::FN_RD_NEXT: begin
					rp_q <= rp_q + sssc_pkg::PTR_W'(1);
				end
				sssc_pkg::FN_SCROLL: begin
					if (len_q > sssc_pkg::CNT_W'(4)) begin
						if (({1'b0, win_inc} + 7'd3) >= {1'b0, len_q}) begin
							win_q <= '0;
						end else begin
							win_q <= win_inc;
						end
					end else if (len_q != '0 && len_q != sssc_pkg::CNT_W'(4)) begin
						for (int i = 0; i < 4; i++) begin
							if (sssc_pkg::CNT_W'(i) >= len_q) begin
								pad_q[i] <= 1'b1;
							end
						end
					end
				end
				sssc_pkg::FN_MUX: begin
					phase_q <= phase_q + 2'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= load_s1;
		end
	end

	always_comb begin
		if (!in_range_s1) begin
			byte_s1 = 8'h00;
		end else if (pad_s1) begin
			byte_s1 = sssc_pkg::CHAR_SPACE;
		end else if (ent_valid_s1) begin
			byte_s1 = mem_s1;
		end else begin
			byte_s1 = init_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q.is_read <= is_read_s1;
			res_q.read_data <= is_read_s1 ? byte_s1 : 8'h00;
			res_q.digit_index <= is_read_s1 ? 2'd0 : digit_s1;
			res_q.segment_pattern <= is_read_s1 ? 7'd0 : sssc_pkg::glyph(byte_s1);
		end
	end

	assign res = res_q;
	assign res_valid = res_valid_q;

	a_wc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= sssc_pkg::CNT_W'(sssc_pkg::BUFFER_DEPTH))
		else $error("write count beyond buffer depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> !cmd_ready)
		else $error("read stage would be overwritten while stalled");

	a_terminator_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.func == sssc_pkg::FN_DATA && !is_printable |=> wc_q == '0)
		else $error("string end did not clear the write count");

	a_window_in_string: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.func == sssc_pkg::FN_SCROLL && len_q > sssc_pkg::CNT_W'(4)
		|=> ({1'b0, win_q} + 7'd3) < {1'b0, len_q})
		else $error("scroll window passed the string end");

	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_read |-> res.digit_index == 2'd0 && res.segment_pattern == 7'd0)
		else $error("read result carries display fields");

endmodule
